### rtl/esl_pkg.sv
// Shared types, register codes and level mapping constants for the edge swipe level control.
package esl_pkg;

  // Event kinds carried on the input tuser field
  localparam logic [1:0] ACT_X    = 2'd0;
  localparam logic [1:0] ACT_Y    = 2'd1;
  localparam logic [1:0] ACT_LIFT = 2'd2;
  localparam logic [1:0] ACT_NONE = 2'd3;

  // Configuration register indexes
  localparam logic [2:0] REG_ZONE_LEFT       = 3'd0;
  localparam logic [2:0] REG_ZONE_RIGHT      = 3'd1;
  localparam logic [2:0] REG_MOVE_THRESHOLD  = 3'd2;
  localparam logic [2:0] REG_ACTIVATION_MS   = 3'd3;
  localparam logic [2:0] REG_REACTIVATION_MS = 3'd4;
  localparam logic [2:0] REG_TIMEOUT_MS      = 3'd5;

  // Level mapping
  localparam int Y_SPAN     = 670;
  localparam int LEVEL_LOW  = 193;
  localparam int LEVEL_HIGH = 19393;

  localparam int SPAN        = (Y_SPAN < 1) ? 1 : Y_SPAN;
  localparam bit LEVEL_DESC  = (LEVEL_HIGH < LEVEL_LOW);
  localparam int LEVEL_DELTA = LEVEL_DESC ? (LEVEL_LOW - LEVEL_HIGH) : (LEVEL_HIGH - LEVEL_LOW);

  // floor(y * DELTA / SPAN) == (y * MAP_MULT) >> MAP_SHIFT for every y <= SPAN
  // as long as 2^MAP_SHIFT > SPAN^2 and MAP_MULT rounds up.
  localparam int MAP_SHIFT = $clog2(longint'(SPAN) * longint'(SPAN) + 1);
  localparam longint unsigned MAP_MULT =
    ((longint'(LEVEL_DELTA) << MAP_SHIFT) + longint'(SPAN) - 1) / longint'(SPAN);
  localparam int MULT_W = (MAP_MULT == 0) ? 1 : $clog2(MAP_MULT + 1);
  localparam int Y_W    = $clog2(SPAN + 1);
  localparam int PROD_W = Y_W + MULT_W;

  typedef struct packed {
    logic [15:0] zone_left;
    logic [15:0] zone_right;
    logic [7:0]  move_threshold;
    logic [15:0] activation_ms;
    logic [15:0] reactivation_ms;
    logic [15:0] timeout_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] coordinate;
    logic [31:0] stamp_ms;
  } item_t;

  typedef struct packed {
    logic        level_write;
    logic [14:0] level;
    logic        zone_on;
  } res_t;

endpackage

### rtl/esl_cfg.sv
// Configuration register file for the edge swipe level control.
module esl_cfg import esl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output cfg_t        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.zone_left       <= 16'd0;
      cfg.zone_right      <= 16'd150;
      cfg.move_threshold  <= 8'd5;
      cfg.activation_ms   <= 16'd2000;
      cfg.reactivation_ms <= 16'd2000;
      cfg.timeout_ms      <= 16'd2000;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ZONE_LEFT:       cfg.zone_left       <= cfg_data;
        REG_ZONE_RIGHT:      cfg.zone_right      <= cfg_data;
        REG_MOVE_THRESHOLD:  cfg.move_threshold  <= cfg_data[7:0];
        REG_ACTIVATION_MS:   cfg.activation_ms   <= cfg_data;
        REG_REACTIVATION_MS: cfg.reactivation_ms <= cfg_data;
        REG_TIMEOUT_MS:      cfg.timeout_ms      <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### rtl/esl_map.sv
// Linear map from a clamped Y coordinate to a brightness level.
module esl_map import esl_pkg::*; (
  input  logic [15:0] coordinate,
  output logic [14:0] level
);

  logic [Y_W-1:0]    y;
  logic [PROD_W-1:0] prod;
  logic [15:0]       quot;
  logic [16:0]       sum;

  assign y    = (coordinate > 16'(SPAN)) ? Y_W'(SPAN) : Y_W'(coordinate);
  // constant reciprocal multiply stands in for the divide by the span
  assign prod = {{MULT_W{1'b0}}, y} * {{Y_W{1'b0}}, MULT_W'(MAP_MULT)};
  assign quot = 16'(prod >> MAP_SHIFT);
  assign sum  = LEVEL_DESC ? ({1'b0, 16'(LEVEL_LOW)} - {1'b0, quot})
                           : ({1'b0, 16'(LEVEL_LOW)} + {1'b0, quot});
  assign level = sum[14:0];

endmodule

### rtl/esl_core.sv
// Touch state tracking and level decision, one event per cycle while fire is high.
module esl_core import esl_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  fire,
  input  item_t item,
  input  cfg_t  cfg,
  output res_t  res
);

  logic [15:0] cur_x, cur_x_next;
  logic        cur_x_known, cur_x_known_next;
  logic [15:0] last_x, last_x_next;
  logic [15:0] last_y, last_y_next;
  logic        last_known, last_known_next;
  logic        started, started_next;
  logic        moving, moving_next;
  logic        zone_enabled, zone_enabled_next;
  logic [31:0] start_stamp, start_stamp_next;
  logic [31:0] adjust_stamp, adjust_stamp_next;
  logic [31:0] off_stamp, off_stamp_next;

  logic [31:0] dt_start, dt_off, dt_adjust;
  logic [15:0] dx, dy;
  logic        moved, in_zone, wr;
  logic [14:0] mapped;

  esl_map u_map (
    .coordinate (item.coordinate),
    .level      (mapped)
  );

  assign dt_start  = item.stamp_ms - start_stamp;
  assign dt_off    = item.stamp_ms - off_stamp;
  assign dt_adjust = item.stamp_ms - adjust_stamp;
  assign dx = (cur_x > last_x) ? (cur_x - last_x) : (last_x - cur_x);
  assign dy = (item.coordinate > last_y) ? (item.coordinate - last_y)
                                         : (last_y - item.coordinate);
  assign moved   = (dx > {8'd0, cfg.move_threshold}) || (dy > {8'd0, cfg.move_threshold});
  assign in_zone = cur_x_known && (cur_x >= cfg.zone_left) && (cur_x <= cfg.zone_right);

  always_comb begin
    cur_x_next        = cur_x;
    cur_x_known_next  = cur_x_known;
    last_x_next       = last_x;
    last_y_next       = last_y;
    last_known_next   = last_known;
    started_next      = started;
    moving_next       = moving;
    zone_enabled_next = zone_enabled;
    start_stamp_next  = start_stamp;
    adjust_stamp_next = adjust_stamp;
    off_stamp_next    = off_stamp;
    wr                = 1'b0;
    case (item.action)
      ACT_X: begin
        cur_x_next       = item.coordinate;
        cur_x_known_next = 1'b1;
      end
      ACT_Y: begin
        if (!started) begin
          started_next     = 1'b1;
          start_stamp_next = item.stamp_ms;
        end else if (dt_start < {16'd0, cfg.activation_ms}) begin
          // hold until the touch has lasted long enough
        end else if (!zone_enabled) begin
          if (dt_off >= {16'd0, cfg.reactivation_ms}) zone_enabled_next = 1'b1;
        end else if (!last_known) begin
          last_x_next     = cur_x;
          last_y_next     = item.coordinate;
          last_known_next = cur_x_known;
        end else begin
          moving_next       = moving | moved;
          wr                = (moving | moved) & in_zone;
          adjust_stamp_next = item.stamp_ms;
          last_x_next       = cur_x;
          last_y_next       = item.coordinate;
        end
      end
      ACT_LIFT: begin
        if (zone_enabled && (dt_adjust >= {16'd0, cfg.timeout_ms})) begin
          zone_enabled_next = 1'b0;
          off_stamp_next    = item.stamp_ms;
        end
        cur_x_next       = 16'd0;
        cur_x_known_next = 1'b0;
        last_x_next      = 16'd0;
        last_y_next      = 16'd0;
        last_known_next  = 1'b0;
        moving_next      = 1'b0;
        started_next     = 1'b0;
      end
      default: ;
    endcase
  end

  assign res.level_write = wr;
  assign res.level       = wr ? mapped : 15'd0;
  assign res.zone_on     = zone_enabled_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x        <= 16'd0;
      cur_x_known  <= 1'b0;
      last_x       <= 16'd0;
      last_y       <= 16'd0;
      last_known   <= 1'b0;
      started      <= 1'b0;
      moving       <= 1'b0;
      zone_enabled <= 1'b1;
      start_stamp  <= 32'd0;
      adjust_stamp <= 32'd0;
      off_stamp    <= 32'd0;
    end else if (fire) begin
      cur_x        <= cur_x_next;
      cur_x_known  <= cur_x_known_next;
      last_x       <= last_x_next;
      last_y       <= last_y_next;
      last_known   <= last_known_next;
      started      <= started_next;
      moving       <= moving_next;
      zone_enabled <= zone_enabled_next;
      start_stamp  <= start_stamp_next;
      adjust_stamp <= adjust_stamp_next;
      off_stamp    <= off_stamp_next;
    end
  end

endmodule

### rtl/edge_swipe_level_control_top.sv
// An input transfer is held in the input register, then its result in the result register, before the output stream.
// Throughput: one event per cycle; the input register and the result register
// advance together whenever the result register is empty or being drained.
// Each event is one pass through the state logic and one constant multiply.
// Reset (rst, synchronous, active high) empties both stages, clears the touch
// state, enables the zone and loads the default configuration.
module edge_swipe_level_control_top import esl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // coordinate[15:0], stamp_ms[47:16]
  input  logic [1:0]  s_tuser,   // action[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // level[14:0], zone_on[15]
  output logic        m_tuser,   // level_write[0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t  cfg;
  item_t item;
  logic  item_valid;
  res_t  res, res_q;
  logic  advance, fire;

  esl_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign cfg_ready = 1'b1;

  // result register free or draining this cycle
  assign advance  = !m_tvalid || m_tready;
  assign fire     = item_valid && advance;
  assign s_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item.action     <= s_tuser;
      item.coordinate <= s_tdata[15:0];
      item.stamp_ms   <= s_tdata[47:16];
    end
  end

  esl_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (item),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) res_q <= res;
  end

  assign m_tdata = {res_q.zone_on, res_q.level};
  assign m_tuser = res_q.level_write;

endmodule
